// File: sv/transfer_sender_session_fsm_assert.svh
// Assertion macros for the transfer sender session back end.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef TRANSFER_SENDER_SESSION_FSM_ASSERT_SVH
`define TRANSFER_SENDER_SESSION_FSM_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check that the consequent holds in the same cycle as the antecedent.
`define TSS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tss check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define TSS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tss check failed");

`else

`define TSS_ASSERT_IMP(lbl, ante, cons)
`define TSS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: sv/tss_pkg.sv
`timescale 1ns / 1ps

package tss_pkg;

	// Size limit for one transfer, in bytes
	localparam logic [31:0] MAX_TRANSFER_BYTES = 32'd1073741824;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Operations, encoded as on the input op field; NOP covers the unused codes
	typedef enum logic [3:0] {
		CMD_INIT        = 4'd0,
		CMD_START       = 4'd1,
		CMD_START_ACK   = 4'd2,
		CMD_WAIT_START  = 4'd3,
		CMD_DATA        = 4'd4,
		CMD_END         = 4'd5,
		CMD_COMMIT_ACK  = 4'd6,
		CMD_WAIT_COMMIT = 4'd7,
		CMD_CANCEL      = 4'd8,
		CMD_CANCEL_ACK  = 4'd9,
		CMD_FAIL        = 4'd10,
		CMD_INTERRUPT   = 4'd11,
		CMD_CONN_LOST   = 4'd12,
		CMD_TICK        = 4'd13,
		CMD_NOP         = 4'd14
	} cmd_t;

	// Stop reasons
	localparam logic [2:0] RS_NONE      = 3'd0;
	localparam logic [2:0] RS_PROTOCOL  = 3'd1;
	localparam logic [2:0] RS_SIZE      = 3'd2;
	localparam logic [2:0] RS_TIMEOUT   = 3'd3;
	localparam logic [2:0] RS_CANCELLED = 3'd4;
	localparam logic [2:0] RS_CONN_LOST = 3'd5;

	// Transfer kinds
	localparam logic [1:0] KIND_MANUAL    = 2'd0;
	localparam logic [1:0] KIND_DRAG      = 2'd1;
	localparam logic [1:0] KIND_CLIPBOARD = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] CFG_TRANSFER_ID   = 3'd0;
	localparam logic [2:0] CFG_TRANSFER_KIND = 3'd1;
	localparam logic [2:0] CFG_CLIP_REVISION = 3'd2;
	localparam logic [2:0] CFG_SESSION_OK    = 3'd3;
	localparam logic [2:0] CFG_START_TICKS   = 3'd4;
	localparam logic [2:0] CFG_COMMIT_TICKS  = 3'd5;

	// Classified operation handed from front to back
	typedef struct packed {
		cmd_t        cmd;
		logic        ack_match;
		logic [2:0]  rc;
		logic        rc_ok;
		logic [31:0] pos;
		logic [31:0] amt;
		logic        size_over;
		logic        id_ok;
		logic [31:0] arm_ticks;
	} item_t;

endpackage

// File: sv/tss_if.sv
`timescale 1ns / 1ps

// Operation channel
interface tss_item_if;
	logic        valid;
	logic        ready;
	logic [3:0]  op;
	logic [31:0] ack_transfer_id;
	logic [2:0]  reason_code;
	logic [31:0] position;
	logic [31:0] amount;

	modport source (output valid, op, ack_transfer_id, reason_code, position, amount,
		input ready);
	modport sink (input valid, op, ack_transfer_id, reason_code, position, amount,
		output ready);
endinterface

// Result channel
interface tss_result_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [2:0]  phase_now;
	logic [2:0]  result_reason;
	logic [31:0] next_offset;
	logic [31:0] final_offset;
	logic        start_acked;
	logic        cancel_pending;
	logic        cancel_acked;

	modport source (output valid, accepted, phase_now, result_reason, next_offset,
		final_offset, start_acked, cancel_pending, cancel_acked, input ready);
	modport sink (input valid, accepted, phase_now, result_reason, next_offset,
		final_offset, start_acked, cancel_pending, cancel_acked, output ready);
endinterface

// Configuration write channel
interface tss_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/tss_front.sv
`timescale 1ns / 1ps

module tss_front (
	input  logic             clk,
	input  logic             arst_n,
	tss_item_if.sink         item,
	tss_cfg_if.sink          cfg,
	output logic             push_valid,
	output tss_pkg::item_t   push_item,
	input  logic             push_ready
);

	logic [31:0] transfer_id_q;
	logic [1:0]  transfer_kind_q;
	logic [63:0] clip_revision_q;
	logic        session_ok_q;
	logic [31:0] start_ticks_q;
	logic [31:0] commit_ticks_q;
	logic        id_ok;
	logic [31:0] start_arm;
	logic [31:0] commit_arm;

	// Take configuration writes at any time
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transfer_id_q   <= '0;
			transfer_kind_q <= '0;
			clip_revision_q <= '0;
			session_ok_q    <= 1'b0;
			start_ticks_q   <= 32'd1;
			commit_ticks_q  <= 32'd1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tss_pkg::CFG_TRANSFER_ID:   transfer_id_q   <= cfg.data[31:0];
				tss_pkg::CFG_TRANSFER_KIND: transfer_kind_q <= cfg.data[1:0];
				tss_pkg::CFG_CLIP_REVISION: clip_revision_q <= cfg.data;
				tss_pkg::CFG_SESSION_OK:    session_ok_q    <= cfg.data[0];
				tss_pkg::CFG_START_TICKS:   start_ticks_q   <= cfg.data[31:0];
				tss_pkg::CFG_COMMIT_TICKS:  commit_ticks_q  <= cfg.data[31:0];
				default: ;
			endcase
		end
	end

	// Check the transfer identity against its kind
	always_comb begin
		id_ok = 1'b0;
		if (transfer_id_q != '0 && session_ok_q) begin
			if (transfer_kind_q == tss_pkg::KIND_CLIPBOARD) begin
				id_ok = (clip_revision_q != '0);
			end else if (transfer_kind_q == tss_pkg::KIND_MANUAL ||
					transfer_kind_q == tss_pkg::KIND_DRAG) begin
				id_ok = (clip_revision_q == '0);
			end
		end
	end

	// A zero tick count counts as one
	assign start_arm  = (start_ticks_q == '0) ? 32'd1 : start_ticks_q;
	assign commit_arm = (commit_ticks_q == '0) ? 32'd1 : commit_ticks_q;

	// Classify the operation and attach the checks that need no session state
	always_comb begin
		push_item.cmd       = (item.op <= 4'(tss_pkg::CMD_TICK)) ?
			tss_pkg::cmd_t'(item.op) : tss_pkg::CMD_NOP;
		push_item.ack_match = (item.ack_transfer_id == transfer_id_q);
		push_item.rc        = item.reason_code;
		push_item.rc_ok     = (item.reason_code <= tss_pkg::RS_CONN_LOST);
		push_item.pos       = item.position;
		push_item.amt       = item.amount;
		push_item.size_over = (item.amount > tss_pkg::MAX_TRANSFER_BYTES);
		push_item.id_ok     = id_ok;
		push_item.arm_ticks = (push_item.cmd == tss_pkg::CMD_WAIT_COMMIT) ?
			commit_arm : start_arm;
	end

	// Pass the transfer straight into the queue
	assign push_valid = item.valid;
	assign item.ready = push_ready;

endmodule

// File: sv/tss_queue.sv
`timescale 1ns / 1ps

module tss_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  tss_pkg::item_t   push_item,
	output logic             push_ready,
	input  logic             pop,
	output logic             head_valid,
	output tss_pkg::item_t   head_item
);

	localparam int unsigned LAST = tss_pkg::QUEUE_DEPTH - 1;

	tss_pkg::item_t                   entries_q [tss_pkg::QUEUE_DEPTH];
	logic [tss_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [tss_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [tss_pkg::QUEUE_CNT_W-1:0] count_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = (count_q != tss_pkg::QUEUE_CNT_W'(tss_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	// Store the entry; entries carry no reset
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == tss_pkg::QUEUE_PTR_W'(LAST)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == tss_pkg::QUEUE_PTR_W'(LAST)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/tss_back.sv
`timescale 1ns / 1ps

`include "transfer_sender_session_fsm_assert.svh"

module tss_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  tss_pkg::item_t   head_item,
	output logic             pop,
	tss_result_if.source     result
);

	typedef enum logic [2:0] {
		PH_CREATED     = 3'd0,
		PH_WAIT_START  = 3'd1,
		PH_STREAMING   = 3'd2,
		PH_WAIT_COMMIT = 3'd3,
		PH_COMMITTED   = 3'd4,
		PH_STOPPED     = 3'd5
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  reason_q, reason_d;
	logic [31:0] total_q, total_d;
	logic [31:0] expected_q, expected_d;
	logic [31:0] end_q, end_d;
	logic        start_ack_q, start_ack_d;
	logic        cancel_q, cancel_d;
	logic        cancel_ack_q, cancel_ack_d;
	logic [31:0] counter_q, counter_d;
	logic        armed_q, armed_d;
	logic        acc;
	logic        can_stop;
	logic        data_ok;
	logic [31:0] counter_dec;

	logic        out_valid_q;
	logic        out_acc_q;
	logic [2:0]  out_phase_q;
	logic [2:0]  out_reason_q;
	logic [31:0] out_next_q;
	logic [31:0] out_final_q;
	logic        out_start_q;
	logic        out_cancel_q;
	logic        out_cancel_ack_q;

	// Take the next operation when the result slot is free or being emptied
	assign pop = head_valid && (!out_valid_q || result.ready);

	assign can_stop    = (phase_q != PH_COMMITTED) && (phase_q != PH_STOPPED);
	assign counter_dec = counter_q - 32'd1;
	assign data_ok     = (head_item.amt != '0) && (head_item.pos == expected_q) &&
		(head_item.pos <= total_q) && (head_item.amt <= total_q - head_item.pos);

	// Apply one operation to the session state
	always_comb begin
		phase_d      = phase_q;
		reason_d     = reason_q;
		total_d      = total_q;
		expected_d   = expected_q;
		end_d        = end_q;
		start_ack_d  = start_ack_q;
		cancel_d     = cancel_q;
		cancel_ack_d = cancel_ack_q;
		counter_d    = counter_q;
		armed_d      = armed_q;
		acc          = 1'b0;
		unique case (head_item.cmd)
			tss_pkg::CMD_INIT: begin
				total_d      = '0;
				expected_d   = '0;
				end_d        = '0;
				start_ack_d  = 1'b0;
				cancel_d     = 1'b0;
				cancel_ack_d = 1'b0;
				counter_d    = '0;
				armed_d      = 1'b0;
				if (head_item.id_ok) begin
					phase_d  = PH_CREATED;
					reason_d = tss_pkg::RS_NONE;
					acc      = 1'b1;
				end else begin
					phase_d  = PH_STOPPED;
					reason_d = tss_pkg::RS_PROTOCOL;
				end
			end
			tss_pkg::CMD_START: begin
				if (phase_q == PH_CREATED) begin
					if (head_item.size_over) begin
						phase_d  = PH_STOPPED;
						reason_d = tss_pkg::RS_SIZE;
					end else begin
						total_d = head_item.amt;
						phase_d = PH_WAIT_START;
						acc     = 1'b1;
					end
				end
			end
			tss_pkg::CMD_START_ACK: begin
				if (head_item.ack_match && phase_q == PH_WAIT_START && head_item.rc_ok) begin
					if (head_item.rc == tss_pkg::RS_NONE) begin
						phase_d     = PH_STREAMING;
						start_ack_d = 1'b1;
					end else begin
						phase_d  = PH_STOPPED;
						reason_d = head_item.rc;
					end
					acc = 1'b1;
				end
			end
			tss_pkg::CMD_WAIT_START: begin
				if (phase_q == PH_CREATED) begin
					phase_d  = PH_STOPPED;
					reason_d = tss_pkg::RS_PROTOCOL;
				end else if (phase_q == PH_WAIT_START) begin
					if (!armed_q) begin
						counter_d = head_item.arm_ticks;
						armed_d   = 1'b1;
					end
					acc = 1'b1;
				end else if (phase_q == PH_STREAMING) begin
					acc = 1'b1;
				end
			end
			tss_pkg::CMD_DATA: begin
				if (phase_q == PH_STREAMING && data_ok) begin
					expected_d = expected_q + head_item.amt;
					acc        = 1'b1;
				end
			end
			tss_pkg::CMD_END: begin
				if (phase_q == PH_STREAMING && head_item.pos == expected_q &&
						head_item.pos == total_q) begin
					end_d   = head_item.pos;
					phase_d = PH_WAIT_COMMIT;
					acc     = 1'b1;
				end
			end
			tss_pkg::CMD_COMMIT_ACK: begin
				if (head_item.ack_match && phase_q == PH_WAIT_COMMIT && head_item.rc_ok) begin
					phase_d = (head_item.rc == tss_pkg::RS_NONE) ? PH_COMMITTED : PH_STOPPED;
					reason_d = head_item.rc;
					acc      = 1'b1;
				end
			end
			tss_pkg::CMD_WAIT_COMMIT: begin
				if (phase_q == PH_CREATED || phase_q == PH_WAIT_START ||
						phase_q == PH_STREAMING) begin
					phase_d  = PH_STOPPED;
					reason_d = tss_pkg::RS_PROTOCOL;
				end else if (phase_q == PH_WAIT_COMMIT) begin
					if (!armed_q) begin
						counter_d = head_item.arm_ticks;
						armed_d   = 1'b1;
					end
					acc = 1'b1;
				end else if (phase_q == PH_COMMITTED) begin
					acc = 1'b1;
				end
			end
			tss_pkg::CMD_CANCEL: begin
				if (phase_q != PH_COMMITTED && !cancel_q &&
						head_item.rc != tss_pkg::RS_NONE && head_item.rc_ok) begin
					if (can_stop) begin
						phase_d  = PH_STOPPED;
						reason_d = head_item.rc;
					end
					cancel_d = 1'b1;
					acc      = 1'b1;
				end
			end
			tss_pkg::CMD_CANCEL_ACK: begin
				if (head_item.ack_match && cancel_q && !cancel_ack_q &&
						head_item.rc == tss_pkg::RS_NONE) begin
					cancel_ack_d = 1'b1;
					acc          = 1'b1;
				end
			end
			tss_pkg::CMD_FAIL: begin
				if (head_item.rc != tss_pkg::RS_NONE && head_item.rc_ok && can_stop) begin
					phase_d  = PH_STOPPED;
					reason_d = head_item.rc;
					acc      = 1'b1;
				end
			end
			tss_pkg::CMD_INTERRUPT: begin
				if (can_stop) begin
					phase_d  = PH_STOPPED;
					reason_d = tss_pkg::RS_CANCELLED;
					acc      = 1'b1;
				end
			end
			tss_pkg::CMD_CONN_LOST: begin
				if (can_stop) begin
					phase_d  = PH_STOPPED;
					reason_d = tss_pkg::RS_CONN_LOST;
					acc      = 1'b1;
				end
			end
			tss_pkg::CMD_TICK: begin
				if (armed_q) begin
					acc       = 1'b1;
					counter_d = counter_dec;
					if (counter_dec == '0) begin
						armed_d = 1'b0;
						if (can_stop) begin
							phase_d  = PH_STOPPED;
							reason_d = tss_pkg::RS_TIMEOUT;
						end
					end
				end
			end
			default: ;
		endcase
		// Drop the timer outside the two wait phases
		if (phase_d != PH_WAIT_START && phase_d != PH_WAIT_COMMIT) begin
			armed_d   = 1'b0;
			counter_d = '0;
		end
	end

	// Hold session state and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_STOPPED;
			reason_q         <= tss_pkg::RS_PROTOCOL;
			total_q          <= '0;
			expected_q       <= '0;
			end_q            <= '0;
			start_ack_q      <= 1'b0;
			cancel_q         <= 1'b0;
			cancel_ack_q     <= 1'b0;
			counter_q        <= '0;
			armed_q          <= 1'b0;
			out_valid_q      <= 1'b0;
			out_acc_q        <= 1'b0;
			out_phase_q      <= '0;
			out_reason_q     <= '0;
			out_next_q       <= '0;
			out_final_q      <= '0;
			out_start_q      <= 1'b0;
			out_cancel_q     <= 1'b0;
			out_cancel_ack_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q          <= phase_d;
				reason_q         <= reason_d;
				total_q          <= total_d;
				expected_q       <= expected_d;
				end_q            <= end_d;
				start_ack_q      <= start_ack_d;
				cancel_q         <= cancel_d;
				cancel_ack_q     <= cancel_ack_d;
				counter_q        <= counter_d;
				armed_q          <= armed_d;
				out_valid_q      <= 1'b1;
				out_acc_q        <= acc;
				out_phase_q      <= phase_d;
				out_reason_q     <= reason_d;
				out_next_q       <= expected_d;
				out_final_q      <= end_d;
				out_start_q      <= start_ack_d;
				out_cancel_q     <= cancel_d;
				out_cancel_ack_q <= cancel_ack_d;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.accepted       = out_acc_q;
	assign result.phase_now      = out_phase_q;
	assign result.result_reason  = out_reason_q;
	assign result.next_offset    = out_next_q;
	assign result.final_offset   = out_final_q;
	assign result.start_acked    = out_start_q;
	assign result.cancel_pending = out_cancel_q;
	assign result.cancel_acked   = out_cancel_ack_q;

	`TSS_ASSERT_IMP(a_armed_in_wait, armed_q, (phase_q == PH_WAIT_START || phase_q == PH_WAIT_COMMIT))
	`TSS_ASSERT_IMP(a_armed_nonzero, armed_q, counter_q != '0)
	`TSS_ASSERT_IMP(a_stream_in_bounds, phase_q == PH_STREAMING, expected_q <= total_q)
	`TSS_ASSERT_IMP(a_commit_clean, phase_q == PH_COMMITTED, reason_q == tss_pkg::RS_NONE)
	`TSS_ASSERT_NXT(a_stall_holds, out_valid_q && !result.ready, out_valid_q)

endmodule

// File: sv/transfer_sender_session_fsm.sv
`timescale 1ns / 1ps
// A result follows its operation transfer through the queue entry, then the result
// register, before it transfers on the result channel.
// Throughput: one operation per cycle while results are taken; the back end updates the
// session state; the 2-entry queue and the result register let each side stall on its own.
// Reset (arst_n low, asynchronous): phase stopped with reason protocol error, counters,
// offsets, flags, queue and result register cleared; registers 0, tick counts 1.

module transfer_sender_session_fsm (
	input  logic          clk,
	input  logic          arst_n,
	tss_item_if.sink      item,
	tss_result_if.source  result,
	tss_cfg_if.sink       cfg
);

	logic           push_valid;
	logic           push_ready;
	tss_pkg::item_t push_item;
	logic           head_valid;
	tss_pkg::item_t head_item;
	logic           pop;

	tss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	tss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	tss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.result     (result)
	);

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import tss_pkg::*;

	localparam int PERIOD_NS = 12;
	localparam logic [3:0] OP_UNUSED_TOP = 4'hF;
	localparam int MIX_COUNT = 4;
	localparam int ITEMS_PER_MIX = 460;
	localparam int ITEMS_PER_SETTING = 120;

	// Session phases as reported on phase_now
	typedef enum logic [2:0] {
		PH_CREATED     = 3'd0,
		PH_WAIT_START  = 3'd1,
		PH_STREAMING   = 3'd2,
		PH_WAIT_COMMIT = 3'd3,
		PH_COMMITTED   = 3'd4,
		PH_STOPPED     = 3'd5
	} phase_t;

	typedef struct packed {
		logic        accepted;
		logic [2:0]  phase_now;
		logic [2:0]  result_reason;
		logic [31:0] next_offset;
		logic [31:0] final_offset;
		logic        start_acked;
		logic        cancel_pending;
		logic        cancel_acked;
	} session_res_t;

	logic clk = 1'b0;
	logic arst_n;

	tss_item_if   item_ch();
	tss_result_if result_ch();
	tss_cfg_if    cfg_ch();

	transfer_sender_session_fsm dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #(PERIOD_NS / 2) clk = ~clk;

	// Register copies
	logic [31:0] reg_transfer_id;
	logic [1:0]  reg_kind;
	logic [63:0] reg_revision;
	logic        reg_session_ok;
	logic [31:0] reg_start_ticks;
	logic [31:0] reg_commit_ticks;

	// Session state copies
	phase_t      sess_phase;
	logic [2:0]  sess_reason;
	logic [31:0] sess_total;
	logic [31:0] sess_next_off;
	logic [31:0] sess_final_off;
	logic        sess_start_acked;
	logic        sess_cancel_queued;
	logic        sess_cancel_acked;
	logic [31:0] ack_timer;
	logic        ack_timer_armed;

	session_res_t pending_results[$];

	int mismatch_count = 0;
	int ops_sent = 0;
	int results_checked = 0;
	int commits_seen = 0;
	int timeouts_seen = 0;
	int settings_used = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int sink_hold_cycles = 0;

	task automatic note_failure(string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endtask

	task automatic reset_predictor();
		reg_transfer_id = '0;
		reg_kind = KIND_MANUAL;
		reg_revision = '0;
		reg_session_ok = 1'b0;
		reg_start_ticks = 32'd1;
		reg_commit_ticks = 32'd1;
		sess_phase = PH_STOPPED;
		sess_reason = RS_PROTOCOL;
		sess_total = '0;
		sess_next_off = '0;
		sess_final_off = '0;
		sess_start_acked = 1'b0;
		sess_cancel_queued = 1'b0;
		sess_cancel_acked = 1'b0;
		ack_timer = '0;
		ack_timer_armed = 1'b0;
	endtask

	function automatic logic identity_valid();
		if (reg_transfer_id == '0 || !reg_session_ok)
			return 1'b0;
		case (reg_kind)
			KIND_CLIPBOARD: return reg_revision != '0;
			KIND_MANUAL, KIND_DRAG: return reg_revision == '0;
			default: return 1'b0;
		endcase
	endfunction

	// Stop unless already terminal; a stop without a reason counts as protocol error
	function automatic logic stop_session(logic [2:0] why);
		if (sess_phase == PH_COMMITTED || sess_phase == PH_STOPPED)
			return 1'b0;
		sess_phase = PH_STOPPED;
		sess_reason = (why == RS_NONE) ? RS_PROTOCOL : why;
		return 1'b1;
	endfunction

	// Arm once; a running timer keeps counting
	function automatic void arm_ack_timer(logic [31:0] ticks);
		if (ack_timer_armed)
			return;
		ack_timer = (ticks == '0) ? 32'd1 : ticks;
		ack_timer_armed = 1'b1;
	endfunction

	// Apply one operation to the session copy and return the result it produces
	function automatic session_res_t advance_session(logic [3:0] op, logic [31:0] ack_id,
		logic [2:0] rc, logic [31:0] pos, logic [31:0] amt);
		session_res_t res;
		logic acc;
		logic rc_ok;
		acc = 1'b0;
		rc_ok = (rc <= RS_CONN_LOST);
		case (op)
			CMD_INIT: begin
				sess_total = '0;
				sess_next_off = '0;
				sess_final_off = '0;
				sess_start_acked = 1'b0;
				sess_cancel_queued = 1'b0;
				sess_cancel_acked = 1'b0;
				ack_timer = '0;
				ack_timer_armed = 1'b0;
				if (identity_valid()) begin
					sess_phase = PH_CREATED;
					sess_reason = RS_NONE;
					acc = 1'b1;
				end else begin
					sess_phase = PH_STOPPED;
					sess_reason = RS_PROTOCOL;
				end
			end
			CMD_START: begin
				if (sess_phase == PH_CREATED) begin
					if (amt > MAX_TRANSFER_BYTES) begin
						void'(stop_session(RS_SIZE));
					end else begin
						sess_total = amt;
						sess_phase = PH_WAIT_START;
						acc = 1'b1;
					end
				end
			end
			CMD_START_ACK: begin
				if (ack_id == reg_transfer_id && sess_phase == PH_WAIT_START && rc_ok) begin
					if (rc == RS_NONE) begin
						sess_phase = PH_STREAMING;
						sess_start_acked = 1'b1;
					end else begin
						void'(stop_session(rc));
					end
					acc = 1'b1;
				end
			end
			CMD_WAIT_START: begin
				if (sess_phase == PH_CREATED) begin
					void'(stop_session(RS_PROTOCOL));
				end else if (sess_phase == PH_WAIT_START) begin
					arm_ack_timer(reg_start_ticks);
					acc = 1'b1;
				end else if (sess_phase == PH_STREAMING) begin
					acc = 1'b1;
				end
			end
			CMD_DATA: begin
				if (sess_phase == PH_STREAMING && amt != '0 && pos == sess_next_off &&
					pos <= sess_total && amt <= sess_total - pos) begin
					sess_next_off = sess_next_off + amt;
					acc = 1'b1;
				end
			end
			CMD_END: begin
				if (sess_phase == PH_STREAMING && pos == sess_next_off && pos == sess_total) begin
					sess_final_off = pos;
					sess_phase = PH_WAIT_COMMIT;
					acc = 1'b1;
				end
			end
			CMD_COMMIT_ACK: begin
				if (ack_id == reg_transfer_id && sess_phase == PH_WAIT_COMMIT && rc_ok) begin
					if (rc == RS_NONE) begin
						sess_phase = PH_COMMITTED;
						sess_reason = RS_NONE;
						commits_seen++;
					end else begin
						void'(stop_session(rc));
					end
					acc = 1'b1;
				end
			end
			CMD_WAIT_COMMIT: begin
				if (sess_phase == PH_CREATED || sess_phase == PH_WAIT_START ||
					sess_phase == PH_STREAMING) begin
					void'(stop_session(RS_PROTOCOL));
				end else if (sess_phase == PH_WAIT_COMMIT) begin
					arm_ack_timer(reg_commit_ticks);
					acc = 1'b1;
				end else if (sess_phase == PH_COMMITTED) begin
					acc = 1'b1;
				end
			end
			CMD_CANCEL: begin
				if (sess_phase != PH_COMMITTED && !sess_cancel_queued && rc != RS_NONE && rc_ok) begin
					void'(stop_session(rc));
					sess_cancel_queued = 1'b1;
					acc = 1'b1;
				end
			end
			CMD_CANCEL_ACK: begin
				if (ack_id == reg_transfer_id && sess_cancel_queued && !sess_cancel_acked &&
					rc == RS_NONE) begin
					sess_cancel_acked = 1'b1;
					acc = 1'b1;
				end
			end
			CMD_FAIL: begin
				if (rc != RS_NONE && rc_ok)
					acc = stop_session(rc);
			end
			CMD_INTERRUPT: acc = stop_session(RS_CANCELLED);
			CMD_CONN_LOST: acc = stop_session(RS_CONN_LOST);
			CMD_TICK: begin
				if (ack_timer_armed) begin
					acc = 1'b1;
					ack_timer = ack_timer - 32'd1;
					if (ack_timer == '0) begin
						ack_timer_armed = 1'b0;
						void'(stop_session(RS_TIMEOUT));
						timeouts_seen++;
					end
				end
			end
			default: ;
		endcase

		// Drop the timer once outside both wait phases
		if (sess_phase != PH_WAIT_START && sess_phase != PH_WAIT_COMMIT) begin
			ack_timer_armed = 1'b0;
			ack_timer = '0;
		end

		res.accepted = acc;
		res.phase_now = sess_phase;
		res.result_reason = sess_reason;
		res.next_offset = sess_next_off;
		res.final_offset = sess_final_off;
		res.start_acked = sess_start_acked;
		res.cancel_pending = sess_cancel_queued;
		res.cancel_acked = sess_cancel_acked;
		return res;
	endfunction

	// Offer one operation, with random idle cycles ahead of it, and log its result
	task automatic send_op(logic [3:0] op, logic [31:0] ack_id, logic [2:0] rc,
		logic [31:0] pos, logic [31:0] amt);
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		item_ch.valid <= 1'b1;
		item_ch.op <= op;
		item_ch.ack_transfer_id <= ack_id;
		item_ch.reason_code <= rc;
		item_ch.position <= pos;
		item_ch.amount <= amt;
		do
			@(posedge clk);
		while (!item_ch.ready);
		pending_results.push_back(advance_session(op, ack_id, rc, pos, amt));
		ops_sent++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			CFG_TRANSFER_ID:   reg_transfer_id = data[31:0];
			CFG_TRANSFER_KIND: reg_kind = data[1:0];
			CFG_CLIP_REVISION: reg_revision = data;
			CFG_SESSION_OK:    reg_session_ok = data[0];
			CFG_START_TICKS:   reg_start_ticks = data[31:0];
			CFG_COMMIT_TICKS:  reg_commit_ticks = data[31:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Drop valid and hold until every result is back
	task automatic wait_idle();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_ack_id();
		return ($urandom_range(99) < 85) ? reg_transfer_id : 32'($urandom);
	endfunction

	function automatic logic [2:0] pick_ack_rc();
		return ($urandom_range(99) < 85) ? RS_NONE : 3'($urandom_range(7));
	endfunction

	function automatic logic [31:0] pick_ticks();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 32'($urandom_range(5, 40));
			default: return 32'($urandom_range(1, 4));
		endcase
	endfunction

	task automatic randomize_regs();
		logic [31:0] tid;
		logic [1:0]  kind;
		logic [63:0] rev;
		logic        ok;
		logic [63:0] junk;
		case ($urandom_range(9))
			0: tid = '0;
			1: tid = '1;
			default: tid = 32'($urandom);
		endcase
		kind = ($urandom_range(9) < 8) ? 2'($urandom_range(2)) : 2'd3;
		if ($urandom_range(9) == 0)
			rev = {32'($urandom), 32'($urandom)};
		else if (kind == KIND_CLIPBOARD)
			rev = $urandom_range(1) ? '1 : ({32'($urandom), 32'($urandom)} | 64'd1);
		else
			rev = '0;
		ok = ($urandom_range(9) != 0);
		junk = {32'($urandom), 32'($urandom)};
		// Upper data bits beyond each register's width carry junk
		write_reg(CFG_TRANSFER_ID, {junk[63:32], tid});
		write_reg(CFG_TRANSFER_KIND, {junk[63:2], kind});
		write_reg(CFG_CLIP_REVISION, rev);
		write_reg(CFG_SESSION_OK, {junk[63:1], ok});
		write_reg(CFG_START_TICKS, {junk[63:32], pick_ticks()});
		write_reg(CFG_COMMIT_TICKS, {junk[31:0], pick_ticks()});
		settings_used++;
	endtask

	task automatic send_noise();
		send_op(4'($urandom_range(15)), pick_ack_id(), 3'($urandom_range(7)),
			$urandom_range(1) ? sess_next_off : 32'($urandom),
			$urandom_range(1) ? 32'($urandom_range(64)) : 32'($urandom));
	endtask

	// One transfer from initialize to commit, with noise, stops and broken steps mixed in
	task automatic run_session();
		int unsigned flavor;
		logic [31:0] total_bytes;
		logic [31:0] remaining;
		logic [31:0] chunk;
		int guard;
		flavor = $urandom_range(99);
		send_op(CMD_INIT, pick_ack_id(), 3'($urandom_range(7)), $urandom, $urandom);
		if (flavor < 6) begin
			repeat ($urandom_range(1, 4)) send_noise();
			return;
		end
		case ($urandom_range(9))
			0: total_bytes = '0;
			1: total_bytes = 32'($urandom_range(MAX_TRANSFER_BYTES - 2, MAX_TRANSFER_BYTES));
			2: total_bytes = 32'($urandom);
			default: total_bytes = 32'($urandom_range(1, 200));
		endcase
		send_op(CMD_START, $urandom, 3'($urandom_range(7)), $urandom, total_bytes);
		if ($urandom_range(9) < 3) begin
			send_op(CMD_WAIT_START, $urandom, 3'($urandom_range(7)), $urandom, $urandom);
			repeat ($urandom_range(0, 3))
				send_op(CMD_TICK, $urandom, 3'($urandom_range(7)), $urandom, $urandom);
		end
		if ($urandom_range(9) == 0)
			send_noise();
		send_op(CMD_START_ACK, pick_ack_id(), pick_ack_rc(), $urandom, $urandom);

		// Stream contiguous chunks until the declared size is covered
		guard = 0;
		while (sess_phase == PH_STREAMING && sess_next_off != sess_total && guard < 64) begin
			remaining = sess_total - sess_next_off;
			if (remaining > 32'd200)
				chunk = $urandom_range(1) ? remaining : 32'($urandom_range(1, remaining));
			else
				chunk = 32'($urandom_range(1, (remaining > 32'd24) ? 24 : remaining));
			if ($urandom_range(24) == 0)
				send_noise();
			else if ($urandom_range(24) == 0)
				send_op(CMD_DATA, $urandom, 3'($urandom_range(7)), sess_next_off + 32'd1, chunk);
			else
				send_op(CMD_DATA, $urandom, 3'($urandom_range(7)), sess_next_off, chunk);
			guard++;
		end

		// Abort paths: cancel, fail, interrupt or connection lost
		if (flavor < 18) begin
			case ($urandom_range(3))
				0: send_op(CMD_CANCEL, $urandom, 3'($urandom_range(7)), $urandom, $urandom);
				1: send_op(CMD_FAIL, $urandom, 3'($urandom_range(7)), $urandom, $urandom);
				2: send_op(CMD_INTERRUPT, $urandom, 3'($urandom_range(7)), $urandom, $urandom);
				default: send_op(CMD_CONN_LOST, $urandom, 3'($urandom_range(7)), $urandom, $urandom);
			endcase
			if ($urandom_range(3) != 0)
				send_op(CMD_CANCEL_ACK, pick_ack_id(), pick_ack_rc(), $urandom, $urandom);
			return;
		end

		if ($urandom_range(19) == 0)
			send_op(CMD_END, $urandom, 3'($urandom_range(7)),
				sess_next_off ^ (32'd1 << $urandom_range(31)), $urandom);
		else
			send_op(CMD_END, $urandom, 3'($urandom_range(7)), sess_next_off, $urandom);
		if ($urandom_range(9) < 7) begin
			send_op(CMD_WAIT_COMMIT, $urandom, 3'($urandom_range(7)), $urandom, $urandom);
			repeat ($urandom_range(0, 3))
				send_op(CMD_TICK, $urandom, 3'($urandom_range(7)), $urandom, $urandom);
		end
		send_op(CMD_COMMIT_ACK, pick_ack_id(), pick_ack_rc(), $urandom, $urandom);
		if ($urandom_range(9) == 0)
			send_noise();
	endtask

	// Registers at reset: zero identity, so initialize must stop
	task automatic test_reset_defaults();
		send_op(CMD_INIT, '0, RS_NONE, '0, '0);
		send_op(CMD_CANCEL, '0, RS_CANCELLED, '0, '0);
		send_op(CMD_CANCEL_ACK, '0, RS_NONE, '0, '0);
	endtask

	// Full transfer at the size limit, with rejected acks and terminal-phase operations
	task automatic test_full_session();
		wait_idle();
		write_reg(CFG_TRANSFER_ID, 64'hFFFF_FFFF);
		write_reg(CFG_TRANSFER_KIND, 64'(KIND_MANUAL));
		write_reg(CFG_CLIP_REVISION, '0);
		write_reg(CFG_SESSION_OK, 64'd1);
		write_reg(CFG_START_TICKS, 64'hFFFF_FFFF);
		write_reg(CFG_COMMIT_TICKS, 64'hFFFF_FFFF);
		settings_used++;
		send_op(CMD_INIT, '0, RS_NONE, '0, '0);
		send_op(CMD_START, '0, RS_NONE, '0, MAX_TRANSFER_BYTES + 32'd1);
		send_op(CMD_INIT, '0, RS_NONE, '0, '0);
		send_op(CMD_START, '0, RS_NONE, '0, MAX_TRANSFER_BYTES);
		send_op(CMD_WAIT_START, '0, RS_NONE, '0, '0);
		send_op(CMD_START_ACK, '0, RS_NONE, '0, '0);
		send_op(CMD_START_ACK, '1, 3'd7, '0, '0);
		send_op(CMD_START_ACK, '1, RS_NONE, '0, '0);
		send_op(CMD_DATA, '0, RS_NONE, '0, '0);
		send_op(CMD_DATA, '0, RS_NONE, '0, MAX_TRANSFER_BYTES);
		send_op(CMD_END, '0, RS_NONE, MAX_TRANSFER_BYTES, '0);
		send_op(CMD_WAIT_COMMIT, '0, RS_NONE, '0, '0);
		send_op(CMD_COMMIT_ACK, '1, RS_NONE, '0, '0);
		send_op(CMD_WAIT_COMMIT, '0, RS_NONE, '0, '0);
		send_op(CMD_INTERRUPT, '0, RS_NONE, '0, '0);
		send_op(OP_UNUSED_TOP, '1, 3'd7, '1, '1);
	endtask

	// Zero tick count, a repeated wait that keeps the running timer, timeout and stops from created
	task automatic test_timeouts_and_stops();
		wait_idle();
		write_reg(CFG_TRANSFER_KIND, 64'(KIND_CLIPBOARD));
		write_reg(CFG_CLIP_REVISION, '1);
		write_reg(CFG_START_TICKS, '0);
		write_reg(CFG_COMMIT_TICKS, 64'd2);
		settings_used++;
		send_op(CMD_INIT, '0, RS_NONE, '0, '0);
		send_op(CMD_START, '0, RS_NONE, '0, '0);
		send_op(CMD_WAIT_START, '0, RS_NONE, '0, '0);
		send_op(CMD_WAIT_START, '0, RS_NONE, '0, '0);
		send_op(CMD_TICK, '0, RS_NONE, '0, '0);
		send_op(CMD_INIT, '0, RS_NONE, '0, '0);
		send_op(CMD_WAIT_START, '0, RS_NONE, '0, '0);
		send_op(CMD_INIT, '0, RS_NONE, '0, '0);
		send_op(CMD_FAIL, '0, 3'd6, '0, '0);
		send_op(CMD_CONN_LOST, '0, RS_NONE, '0, '0);
	endtask

	// Random transfers under each idle mix, with fresh register settings along the way
	task automatic test_random_mixes();
		int src_mix[MIX_COUNT];
		int sink_mix[MIX_COUNT];
		int mix_start;
		int setting_start;
		src_mix = '{0, 76, 0, 26};
		sink_mix = '{0, 0, 76, 26};
		for (int m = 0; m < MIX_COUNT; m++) begin
			src_idle_pct = src_mix[m];
			sink_stall_pct = sink_mix[m];
			mix_start = ops_sent;
			setting_start = ops_sent - ITEMS_PER_SETTING;
			while (ops_sent - mix_start < ITEMS_PER_MIX) begin
				if (ops_sent - setting_start >= ITEMS_PER_SETTING) begin
					wait_idle();
					randomize_regs();
					setting_start = ops_sent;
				end
				run_session();
			end
			wait_idle();
		end
	endtask

	// Hold the output off long enough that the block backs up into its input
	task automatic test_output_backpressure();
		int start_count;
		wait_idle();
		write_reg(CFG_TRANSFER_ID, 64'($urandom | 1));
		write_reg(CFG_TRANSFER_KIND, 64'(KIND_DRAG));
		write_reg(CFG_CLIP_REVISION, '0);
		write_reg(CFG_SESSION_OK, 64'd1);
		settings_used++;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		sink_hold_cycles = 150;
		start_count = ops_sent;
		while (ops_sent - start_count < 60)
			run_session();
	endtask

	// Result side: random stalls, plus a counted hold-off when requested
	always @(negedge clk) begin
		if (sink_hold_cycles > 0) begin
			result_ch.ready <= 1'b0;
			sink_hold_cycles <= sink_hold_cycles - 1;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		session_res_t got;
		session_res_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.accepted = result_ch.accepted;
			got.phase_now = result_ch.phase_now;
			got.result_reason = result_ch.result_reason;
			got.next_offset = result_ch.next_offset;
			got.final_offset = result_ch.final_offset;
			got.start_acked = result_ch.start_acked;
			got.cancel_pending = result_ch.cancel_pending;
			got.cancel_acked = result_ch.cancel_acked;
			if (pending_results.size() == 0) begin
				note_failure($sformatf("tb_top: unexpected result at %0t", $realtime));
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got.accepted !== want.accepted || got.phase_now !== want.phase_now ||
					got.result_reason !== want.result_reason ||
					got.next_offset !== want.next_offset ||
					got.final_offset !== want.final_offset ||
					got.start_acked !== want.start_acked ||
					got.cancel_pending !== want.cancel_pending ||
					got.cancel_acked !== want.cancel_acked)
					note_failure($sformatf({"tb_top: result %0d mismatch: ",
						"exp acc=%0d ph=%0d rs=%0d next=%h fin=%h flags=%b%b%b, ",
						"got acc=%0d ph=%0d rs=%0d next=%h fin=%h flags=%b%b%b"},
						results_checked, want.accepted, want.phase_now, want.result_reason,
						want.next_offset, want.final_offset, want.start_acked,
						want.cancel_pending, want.cancel_acked, got.accepted, got.phase_now,
						got.result_reason, got.next_offset, got.final_offset, got.start_acked,
						got.cancel_pending, got.cancel_acked));
			end
		end
	end

	initial begin
		#(PERIOD_NS * 300000);
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		int waited;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.op = '0;
		item_ch.ack_transfer_id = '0;
		item_ch.reason_code = '0;
		item_ch.position = '0;
		item_ch.amount = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		result_ch.ready = 1'b0;
		reset_predictor();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_full_session();
		test_timeouts_and_stops();
		test_random_mixes();
		test_output_backpressure();

		// Drain the remaining results, bounded
		@(negedge clk);
		item_ch.valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			note_failure($sformatf("tb_top: %0d results never arrived",
				pending_results.size()));

		$display("tb_top: %0d operations over %0d register settings, %0d results checked",
			ops_sent, settings_used, results_checked);
		$display("tb_top: %0d commits and %0d ack timeouts seen under four idle mixes",
			commits_seen, timeouts_seen);
		if (mismatch_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/tss_pkg.sv
sv/tss_if.sv
sv/tss_front.sv
sv/tss_queue.sv
sv/tss_back.sv
sv/transfer_sender_session_fsm.sv
tb/tb_top.sv
